// ===== rtl/core/btlv_pkg.sv =====
`default_nettype none

package btlv_pkg;

    localparam int MAX_LENGTH_OCTETS_DEF = 4;

    localparam logic [4:0] TAG_LOW_ESC     = 5'h1F;
    localparam logic [2:0] TAG_COUNT_LIMIT = 3'd5;

    localparam logic [1:0] ERR_NONE   = 2'd0;
    localparam logic [1:0] ERR_TAG    = 2'd1;
    localparam logic [1:0] ERR_LENGTH = 2'd2;

    typedef enum logic [1:0] {
        PH_ID_FIRST  = 2'd0,
        PH_ID_MORE   = 2'd1,
        PH_LEN_FIRST = 2'd2,
        PH_LEN_MORE  = 2'd3
    } phase_t;

    typedef struct packed {
        logic [1:0]  tag_class;
        logic        constructed;
        logic [27:0] tag_number;
        logic [2:0]  tag_octet_count;
        logic [31:0] length_value;
        logic [2:0]  length_octet_count;
        logic        indefinite;
        logic [1:0]  error_code;
    } result_t;

endpackage

`default_nettype wire

// ===== rtl/core/btlv_in_stage.sv =====
`default_nettype none

module btlv_in_stage
    import btlv_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [7:0] header_byte,
    input  wire logic       take,
    output logic            byte_valid,
    output logic [7:0]      byte_data
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] data_reg;
    logic       accept;

    assign in_stall   = valid_reg && !take;
    assign accept     = in_valid && !in_stall;
    assign byte_valid = valid_reg;
    assign byte_data  = data_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            data_reg <= header_byte;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/btlv_decode.sv =====
`default_nettype none

module btlv_decode
    import btlv_pkg::*;
#(
    parameter int MAX_LENGTH_OCTETS = MAX_LENGTH_OCTETS_DEF
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       byte_valid,
    input  wire logic [7:0] byte_data,
    input  wire logic       out_free,
    output logic            take,
    output logic            emit,
    output result_t         result
);

    localparam int REM_W = $clog2(MAX_LENGTH_OCTETS + 1);
    localparam logic [REM_W-1:0] REM_MAX = REM_W'(MAX_LENGTH_OCTETS);
    localparam logic [6:0] ANNOUNCE_MAX = 7'(MAX_LENGTH_OCTETS);

    phase_t            phase_reg, phase_next;
    logic [1:0]        class_reg, class_next;
    logic              cons_reg, cons_next;
    logic [27:0]       tag_acc_reg, tag_acc_next;
    logic [2:0]        tag_count_reg, tag_count_next;
    logic [31:0]       len_acc_reg, len_acc_next;
    logic [REM_W-1:0]  len_rem_reg, len_rem_next;
    logic [2:0]        len_count_reg, len_count_next;
    logic              ovf_reg, ovf_next;
    logic              indef;
    logic              done;

    always_comb
    begin
        phase_next     = phase_reg;
        class_next     = class_reg;
        cons_next      = cons_reg;
        tag_acc_next   = tag_acc_reg;
        tag_count_next = tag_count_reg;
        len_acc_next   = len_acc_reg;
        len_rem_next   = len_rem_reg;
        len_count_next = len_count_reg;
        ovf_next       = ovf_reg;
        indef          = 1'b0;
        done           = 1'b0;
        case (phase_reg)
            PH_ID_FIRST:
            begin
                class_next     = byte_data[7:6];
                cons_next      = byte_data[5];
                tag_count_next = 3'd1;
                ovf_next       = 1'b0;
                if (byte_data[4:0] == TAG_LOW_ESC)
                begin
                    tag_acc_next = '0;
                    phase_next   = PH_ID_MORE;
                end
                else
                begin
                    tag_acc_next = {23'd0, byte_data[4:0]};
                    phase_next   = PH_LEN_FIRST;
                end
            end
            PH_ID_MORE:
            begin
                tag_acc_next   = {tag_acc_reg[20:0], byte_data[6:0]};
                tag_count_next = tag_count_reg + 3'd1;
                if (!byte_data[7] || (tag_count_next >= TAG_COUNT_LIMIT))
                begin
                    phase_next = PH_LEN_FIRST;
                end
            end
            PH_LEN_FIRST:
            begin
                len_count_next = 3'd1;
                len_acc_next   = '0;
                ovf_next       = 1'b0;
                if (!byte_data[7])
                begin
                    len_acc_next = {24'd0, byte_data};
                    done         = 1'b1;
                    phase_next   = PH_ID_FIRST;
                end
                else
                begin
                    if (byte_data[6:0] > ANNOUNCE_MAX)
                    begin
                        ovf_next     = 1'b1;
                        len_rem_next = REM_MAX;
                    end
                    else
                    begin
                        len_rem_next = byte_data[REM_W-1:0];
                    end
                    if (byte_data[6:0] == 7'd0)
                    begin
                        indef      = 1'b1;
                        done       = 1'b1;
                        phase_next = PH_ID_FIRST;
                    end
                    else
                    begin
                        phase_next = PH_LEN_MORE;
                    end
                end
            end
            default:
            begin
                len_acc_next   = {len_acc_reg[23:0], byte_data};
                len_count_next = len_count_reg + 3'd1;
                if (len_rem_reg != '0)
                begin
                    len_rem_next = len_rem_reg - REM_W'(1);
                end
                if (len_rem_next == '0)
                begin
                    indef      = (len_acc_next == 32'd0);
                    done       = 1'b1;
                    phase_next = PH_ID_FIRST;
                end
            end
        endcase
    end

    assign emit = byte_valid && done;
    assign take = byte_valid && (!done || out_free);

    always_comb
    begin
        result.tag_class          = class_reg;
        result.constructed        = cons_reg;
        result.tag_number         = tag_acc_reg;
        result.tag_octet_count    = tag_count_reg;
        result.length_value       = len_acc_next;
        result.length_octet_count = len_count_next;
        result.indefinite         = indef;
        if (tag_count_reg >= TAG_COUNT_LIMIT)
        begin
            result.error_code = ERR_TAG;
        end
        else if (ovf_next)
        begin
            result.error_code = ERR_LENGTH;
        end
        else
        begin
            result.error_code = ERR_NONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_ID_FIRST;
            class_reg     <= '0;
            cons_reg      <= 1'b0;
            tag_acc_reg   <= '0;
            tag_count_reg <= '0;
            len_acc_reg   <= '0;
            len_rem_reg   <= '0;
            len_count_reg <= '0;
            ovf_reg       <= 1'b0;
        end
        else if (take)
        begin
            phase_reg     <= phase_next;
            class_reg     <= class_next;
            cons_reg      <= cons_next;
            tag_acc_reg   <= tag_acc_next;
            tag_count_reg <= tag_count_next;
            len_acc_reg   <= len_acc_next;
            len_rem_reg   <= len_rem_next;
            len_count_reg <= len_count_next;
            ovf_reg       <= ovf_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/btlv_out_stage.sv =====
`default_nettype none

module btlv_out_stage
    import btlv_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    push,
    input  wire result_t result,
    output logic         out_free,
    output logic         out_valid,
    input  wire logic    out_stall,
    output result_t      out_result
);

    logic    valid_reg;
    logic    valid_next;
    result_t result_reg;

    assign out_free   = !valid_reg || !out_stall;
    assign out_valid  = valid_reg;
    assign out_result = result_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (push)
        begin
            valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            result_reg <= result;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/ber_tlv_header_decoder.sv =====
// ber tlv header decoder: one header byte accepted per cycle, sustained while not stalled
// a header's last byte waits in the input register until its result can enter the result register
// throughput: one byte per cycle; input register, one decode pass, result register
// a stalled result holds back only a byte that would finish another header
// reset (rst_n, async, active low) empties both registers and returns to the identifier octet
`default_nettype none

module ber_tlv_header_decoder
    import btlv_pkg::*;
#(
    parameter int MAX_LENGTH_OCTETS = MAX_LENGTH_OCTETS_DEF
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [7:0] header_byte,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [1:0]      tag_class,
    output logic            constructed,
    output logic [27:0]     tag_number,
    output logic [2:0]      tag_octet_count,
    output logic [31:0]     length_value,
    output logic [2:0]      length_octet_count,
    output logic            indefinite,
    output logic [1:0]      error_code
);

    logic       take;
    logic       emit;
    logic       out_free;
    logic       byte_valid;
    logic [7:0] byte_data;
    result_t    result;
    result_t    out_result;

    btlv_in_stage u_in
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .header_byte (header_byte),
        .take        (take),
        .byte_valid  (byte_valid),
        .byte_data   (byte_data)
    );

    btlv_decode #(
        .MAX_LENGTH_OCTETS (MAX_LENGTH_OCTETS)
    ) u_decode
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_data  (byte_data),
        .out_free   (out_free),
        .take       (take),
        .emit       (emit),
        .result     (result)
    );

    btlv_out_stage u_out
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (emit && take),
        .result     (result),
        .out_free   (out_free),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_result (out_result)
    );

    assign tag_class          = out_result.tag_class;
    assign constructed        = out_result.constructed;
    assign tag_number         = out_result.tag_number;
    assign tag_octet_count    = out_result.tag_octet_count;
    assign length_value       = out_result.length_value;
    assign length_octet_count = out_result.length_octet_count;
    assign indefinite         = out_result.indefinite;
    assign error_code         = out_result.error_code;

endmodule

`default_nettype wire

// ===== sim/ber_tlv_header_checker.sv =====
`timescale 1ns / 1ps

module ber_tlv_header_checker
    import btlv_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    input  wire logic        in_stall,
    input  wire logic [7:0]  header_byte,
    input  wire logic        out_valid,
    input  wire logic        out_stall,
    input  wire logic [1:0]  tag_class,
    input  wire logic        constructed,
    input  wire logic [27:0] tag_number,
    input  wire logic [2:0]  tag_octet_count,
    input  wire logic [31:0] length_value,
    input  wire logic [2:0]  length_octet_count,
    input  wire logic        indefinite,
    input  wire logic [1:0]  error_code,
    output int               fail_count,
    output int               pending
);

    phase_t      phase;
    logic [1:0]  id_class;
    logic        id_constructed;
    logic [27:0] tag_acc;
    logic [2:0]  tag_octets;
    logic [31:0] len_acc;
    int          len_left;
    logic [2:0]  len_octets;
    logic        len_too_long;
    result_t     header_q[$];
    result_t     want;
    int          fails;

    task automatic finish_header(input logic indef);
        result_t r;
        r.tag_class          = id_class;
        r.constructed        = id_constructed;
        r.tag_number         = tag_acc;
        r.tag_octet_count    = tag_octets;
        r.length_value       = len_acc;
        r.length_octet_count = len_octets;
        r.indefinite         = indef;
        if (tag_octets >= TAG_COUNT_LIMIT)
            r.error_code = ERR_TAG;
        else if (len_too_long)
            r.error_code = ERR_LENGTH;
        else
            r.error_code = ERR_NONE;
        header_q.push_back(r);
        phase = PH_ID_FIRST;
    endtask

    task automatic decode_byte(input logic [7:0] b);
        case (phase)
            PH_ID_FIRST:
            begin
                id_class       = b[7:6];
                id_constructed = b[5];
                tag_octets     = 3'd1;
                len_too_long   = 1'b0;
                if (b[4:0] == TAG_LOW_ESC)
                begin
                    tag_acc = '0;
                    phase   = PH_ID_MORE;
                end
                else
                begin
                    tag_acc = {23'd0, b[4:0]};
                    phase   = PH_LEN_FIRST;
                end
            end
            PH_ID_MORE:
            begin
                tag_acc    = {tag_acc[20:0], b[6:0]};
                tag_octets = tag_octets + 3'd1;
                if (!b[7] || tag_octets >= TAG_COUNT_LIMIT)
                    phase = PH_LEN_FIRST;
            end
            PH_LEN_FIRST:
            begin
                len_octets   = 3'd1;
                len_acc      = '0;
                len_too_long = 1'b0;
                if (!b[7])
                begin
                    len_acc = {24'd0, b};
                    finish_header(1'b0);
                end
                else
                begin
                    len_left = int'(b[6:0]);
                    if (len_left > MAX_LENGTH_OCTETS_DEF)
                    begin
                        len_too_long = 1'b1;
                        len_left     = MAX_LENGTH_OCTETS_DEF;
                    end
                    if (len_left == 0)
                        finish_header(1'b1);
                    else
                        phase = PH_LEN_MORE;
                end
            end
            default:
            begin
                len_acc    = {len_acc[23:0], b};
                len_octets = len_octets + 3'd1;
                if (len_left > 0)
                    len_left--;
                if (len_left == 0)
                    finish_header(len_acc == 32'd0);
            end
        endcase
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] got_v);
        if (exp_v !== got_v)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, got_v);
            fails++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase          = PH_ID_FIRST;
            id_class       = '0;
            id_constructed = 1'b0;
            tag_acc        = '0;
            tag_octets     = '0;
            len_acc        = '0;
            len_left       = 0;
            len_octets     = '0;
            len_too_long   = 1'b0;
            header_q.delete();
            fails          = 0;
            fail_count    <= 0;
            pending       <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (header_q.size() == 0)
                begin
                    $display("%0t: unexpected result item, expected none, actual tag %0h len %0h",
                             $time, tag_number, length_value);
                    fails++;
                end
                else
                begin
                    want = header_q.pop_front();
                    check_field("tag_class", 32'(want.tag_class), 32'(tag_class));
                    check_field("constructed", 32'(want.constructed), 32'(constructed));
                    check_field("tag_number", 32'(want.tag_number), 32'(tag_number));
                    check_field("tag_octet_count", 32'(want.tag_octet_count),
                                32'(tag_octet_count));
                    check_field("length_value", want.length_value, length_value);
                    check_field("length_octet_count", 32'(want.length_octet_count),
                                32'(length_octet_count));
                    check_field("indefinite", 32'(want.indefinite), 32'(indefinite));
                    check_field("error_code", 32'(want.error_code), 32'(error_code));
                end
            end
            if (in_valid && !in_stall)
                decode_byte(header_byte);
            fail_count <= fails;
            pending    <= header_q.size();
        end
    end

endmodule

// ===== sim/tb_ber_tlv_header_decoder.sv =====
`timescale 1ns / 1ps

module tb_ber_tlv_header_decoder;

    import btlv_pkg::*;

    localparam int IDLE_LIMIT  = 2000;
    localparam int BYTE_TARGET = 1900;
    localparam int HOLD_CYCLES = 300;

    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        in_valid    = 1'b0;
    logic        in_stall;
    logic [7:0]  header_byte = 8'h00;
    logic        out_valid;
    logic        out_stall   = 1'b0;
    logic [1:0]  tag_class;
    logic        constructed;
    logic [27:0] tag_number;
    logic [2:0]  tag_octet_count;
    logic [31:0] length_value;
    logic [2:0]  length_octet_count;
    logic        indefinite;
    logic [1:0]  error_code;
    int          fail_count;
    int          pending;

    int          sent      = 0;
    int          idle_run  = 0;
    logic        hold_req  = 1'b0;
    logic        tx_calm   = 1'b0;
    logic        rx_calm   = 1'b0;
    logic [7:0]  directed_bytes [0:26];

    always #5 clk = ~clk;

    ber_tlv_header_decoder dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (in_valid),
        .in_stall           (in_stall),
        .header_byte        (header_byte),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .tag_class          (tag_class),
        .constructed        (constructed),
        .tag_number         (tag_number),
        .tag_octet_count    (tag_octet_count),
        .length_value       (length_value),
        .length_octet_count (length_octet_count),
        .indefinite         (indefinite),
        .error_code         (error_code)
    );

    ber_tlv_header_checker chk (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (in_valid),
        .in_stall           (in_stall),
        .header_byte        (header_byte),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .tag_class          (tag_class),
        .constructed        (constructed),
        .tag_number         (tag_number),
        .tag_octet_count    (tag_octet_count),
        .length_value       (length_value),
        .length_octet_count (length_octet_count),
        .indefinite         (indefinite),
        .error_code         (error_code),
        .fail_count         (fail_count),
        .pending            (pending)
    );

    task automatic send_byte(input logic [7:0] b);
        int gap;
        if ($urandom_range(0, 49) == 0)
            tx_calm = !tx_calm;
        gap = tx_calm ? 0 : $urandom_range(0, 7);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        header_byte <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sent++;
    endtask

    task automatic drain_headers();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    task automatic send_ident();
        logic [7:0] b;
        logic [7:0] g;
        int         extra;
        b = 8'($urandom);
        if ($urandom_range(0, 1) == 0)
        begin
            b[4:0] = 5'($urandom_range(0, 30));
            send_byte(b);
        end
        else
        begin
            b[4:0] = TAG_LOW_ESC;
            send_byte(b);
            extra = $urandom_range(1, 4);
            for (int i = 0; i < extra; i++)
            begin
                g = 8'($urandom);
                if (i < extra - 1)
                    g[7] = 1'b1;
                else if (extra < 4)
                    g[7] = 1'b0;
                send_byte(g);
            end
        end
    endtask

    task automatic send_length();
        logic [7:0] v;
        int         kind;
        int         n;
        int         reads;
        kind = $urandom_range(0, 9);
        if (kind < 4)
        begin
            v = 8'($urandom_range(0, 127));
            send_byte(v);
        end
        else
        begin
            n     = (kind < 8) ? $urandom_range(0, 4) : $urandom_range(5, 127);
            reads = (n > 4) ? 4 : n;
            send_byte({1'b1, 7'(n)});
            for (int i = 0; i < reads; i++)
            begin
                case ($urandom_range(0, 5))
                    0:       v = 8'h00;
                    1:       v = 8'hFF;
                    default: v = 8'($urandom);
                endcase
                send_byte(v);
            end
        end
    endtask

    task automatic send_noise();
        int k;
        k = $urandom_range(1, 6);
        for (int i = 0; i < k; i++)
            send_byte(8'($urandom));
    endtask

    initial
    begin
        int  n;
        forever
        begin
            if (hold_req)
            begin
                hold_req = 1'b0;
                n = HOLD_CYCLES;
            end
            else
            begin
                if ($urandom_range(0, 49) == 0)
                    rx_calm = !rx_calm;
                n = rx_calm ? 0 : $urandom_range(0, 7);
            end
            if (n > 0)
            begin
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_run <= 0;
        else if (idle_run + 1 >= IDLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
        else
            idle_run <= idle_run + 1;
    end

    initial
    begin
        logic held;
        logic paused;
        held   = 1'b0;
        paused = 1'b0;
        directed_bytes = '{
            8'h00, 8'h00,
            8'hFE, 8'h81, 8'h00,
            8'hBF, 8'hFF, 8'hFF, 8'hFF, 8'h7F, 8'h80,
            8'h5F, 8'h80, 8'h80, 8'h80, 8'h80, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
            8'h60, 8'hFF, 8'h12, 8'h34, 8'h56, 8'h78
        };
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // extremes, indefinite forms, tag overrun, length overrun and both
        foreach (directed_bytes[i])
            send_byte(directed_bytes[i]);

        while (sent < BYTE_TARGET)
        begin
            if (!held && sent >= 700)
            begin
                hold_req = 1'b1;
                held     = 1'b1;
            end
            if (!paused && sent >= 1300)
            begin
                drain_headers();
                paused = 1'b1;
            end
            if ($urandom_range(0, 99) < 12)
                send_noise();
            else
            begin
                send_ident();
                send_length();
            end
        end

        // wait until every finished header has come out
        drain_headers();
        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/btlv_pkg.sv
rtl/core/btlv_in_stage.sv
rtl/core/btlv_decode.sv
rtl/core/btlv_out_stage.sv
rtl/core/ber_tlv_header_decoder.sv
sim/ber_tlv_header_checker.sv
sim/tb_ber_tlv_header_decoder.sv
